// ----- sv/rbuv_pkg.sv -----
// rbuv_pkg: widths, codes and helper functions for the rotation between unit vectors block
// used by rotation_between_unit_vectors; depends on nothing else
package rbuv_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int FRAC_BITS = 14;
    localparam int THR_W     = 14;
    localparam int THR_RESET = 2;

    localparam int PROD_W = 2 * IN_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int C_W    = DOT_W - FRAC_BITS;
    localparam int CR_W   = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int ROOT_W = SQ_W / 2;
    localparam int S_W    = ROOT_W - FRAC_BITS + 1;
    localparam int V_W    = IN_W + 1;
    localparam int AX_W   = FRAC_BITS + 3;
    localparam int NUM_W  = CR_W + FRAC_BITS + 3;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int QB     = FRAC_BITS + 2;
    localparam int T_W    = C_W + 1;
    localparam int TU_W   = T_W + AX_W - FRAC_BITS;
    localparam int TUV_W  = TU_W + AX_W - FRAC_BITS;
    localparam int SS_W   = S_W + 1 + AX_W - FRAC_BITS;
    localparam int ENT_W  = TUV_W + 2;

    localparam int ONE      = 1 << FRAC_BITS;
    localparam int RND_HALF = 1 << (FRAC_BITS - 1);
    localparam int SAT_HI   = (1 << (OUT_W - 1)) - 1;
    localparam int SAT_LO   = -(1 << (OUT_W - 1));

    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_THRESH = '0;

    typedef enum logic [1:0] {
        CASE_GENERAL  = 2'd0,
        CASE_SAME     = 2'd1,
        CASE_OPPOSITE = 2'd2
    } case_t;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } sqrt_step_t;

    typedef struct packed {
        logic signed [C_W-1:0]  c;
        logic signed [CR_W-1:0] crx;
        logic signed [CR_W-1:0] cry;
        logic signed [CR_W-1:0] crz;
        logic signed [V_W-1:0]  vx;
        logic signed [V_W-1:0]  vy;
        logic signed [V_W-1:0]  vz;
    } root_side_t;

    typedef struct packed {
        logic signed [C_W-1:0] c;
        logic [S_W-1:0]        s;
        case_t                 kase;
        logic [2:0]            neg;
        logic                  zero;
    } div_side_t;

    // one digit of the restoring integer square root
    function automatic sqrt_step_t sqrt_step(input logic [SQ_W-1:0] v,
                                             input logic [SQ_W-1:0] r,
                                             input logic [SQ_W-1:0] bitv);
        logic [SQ_W-1:0] trial;
        sqrt_step_t      o;
        trial = r + bitv;
        if (v >= trial)
        begin
            o.v = v - trial;
            o.r = (r >> 1) + bitv;
        end
        else
        begin
            o.v = v;
            o.r = r >> 1;
        end
        return o;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ENT_W-1:0] e);
        logic signed [OUT_W-1:0] o;
        if (e > SAT_HI)
            o = OUT_W'(SAT_HI);
        else if (e < SAT_LO)
            o = OUT_W'(SAT_LO);
        else
            o = OUT_W'(e);
        return o;
    endfunction

endpackage

// ----- sv/rotation_between_unit_vectors.sv -----
// rotation_between_unit_vectors: pipelined axis-angle rotation matrix from two vectors
// depends on rbuv_pkg
//
// A transaction is taken at every clock edge where start is high; busy is always low, so a new
// vector pair can enter every cycle. The 3x3 matrix and case_taken appear on the result ports
// with done high for exactly one cycle, in issue order. The pipeline holds the square root
// (one result bit per stage, 32 stages) followed by the axis divider (one quotient bit per
// stage, 16 stages). The receiver cannot stall the block. collinear_threshold sits at byte
// address 0; the user must write it through the APB port only while idle, which the block
// itself does not enforce.
module rotation_between_unit_vectors
    import rbuv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [IN_W-1:0]  from_x,
    input  logic signed [IN_W-1:0]  from_y,
    input  logic signed [IN_W-1:0]  from_z,
    input  logic signed [IN_W-1:0]  to_x,
    input  logic signed [IN_W-1:0]  to_y,
    input  logic signed [IN_W-1:0]  to_z,
    output logic                    done,
    output logic signed [OUT_W-1:0] m00,
    output logic signed [OUT_W-1:0] m01,
    output logic signed [OUT_W-1:0] m02,
    output logic signed [OUT_W-1:0] m10,
    output logic signed [OUT_W-1:0] m11,
    output logic signed [OUT_W-1:0] m12,
    output logic signed [OUT_W-1:0] m20,
    output logic signed [OUT_W-1:0] m21,
    output logic signed [OUT_W-1:0] m22,
    output logic [1:0]              case_taken
);

    localparam int LATENCY = 5 + ROOT_W + 1 + QB + 4;

    // ---------------- configuration ----------------
    logic [THR_W-1:0] thresh_reg;
    logic             thr_sel;

    assign thr_sel = (paddr[ADDR_W-1:2] == REG_THRESH);
    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign prdata  = thr_sel ? {{(32-THR_W){1'b0}}, thresh_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= THR_W'(THR_RESET);
        else if (psel && penable && pwrite && pready && thr_sel)
            thresh_reg <= pwdata[THR_W-1:0];
    end

    // ---------------- stage 1: capture ----------------
    logic                   v1_reg;
    logic signed [IN_W-1:0] a1_reg [3];
    logic signed [IN_W-1:0] b1_reg [3];

    always_ff @(posedge clk)
    begin
        a1_reg[0] <= from_x;
        a1_reg[1] <= from_y;
        a1_reg[2] <= from_z;
        b1_reg[0] <= to_x;
        b1_reg[1] <= to_y;
        b1_reg[2] <= to_z;
    end

    // ---------------- stage 2: products, fallback axis ----------------
    logic                     v2_reg;
    logic signed [PROD_W-1:0] pd2_reg [3];
    logic signed [PROD_W-1:0] pc2_reg [6];
    logic signed [V_W-1:0]    vv2_reg [3];
    logic signed [V_W-1:0]    ae [3];
    logic [V_W-1:0]           aa [3];
    logic signed [V_W-1:0]    vv_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ae[i] = V_W'(a1_reg[i]);
            aa[i] = ae[i][V_W-1] ? V_W'(-ae[i]) : V_W'(ae[i]);
        end
        // smallest |a| component, ties to the lower index
        priority if (aa[0] <= aa[1] && aa[0] <= aa[2])
        begin
            vv_next[0] = '0;
            vv_next[1] = ae[2];
            vv_next[2] = -ae[1];
        end
        else if (aa[0] <= aa[1])
        begin
            vv_next[0] = ae[1];
            vv_next[1] = -ae[0];
            vv_next[2] = '0;
        end
        else if (aa[1] <= aa[2])
        begin
            vv_next[0] = -ae[2];
            vv_next[1] = '0;
            vv_next[2] = ae[0];
        end
        else
        begin
            vv_next[0] = ae[1];
            vv_next[1] = -ae[0];
            vv_next[2] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pd2_reg[i] <= a1_reg[i] * b1_reg[i];
            vv2_reg[i] <= vv_next[i];
        end
        pc2_reg[0] <= a1_reg[1] * b1_reg[2];
        pc2_reg[1] <= a1_reg[2] * b1_reg[1];
        pc2_reg[2] <= a1_reg[2] * b1_reg[0];
        pc2_reg[3] <= a1_reg[0] * b1_reg[2];
        pc2_reg[4] <= a1_reg[0] * b1_reg[1];
        pc2_reg[5] <= a1_reg[1] * b1_reg[0];
    end

    // ---------------- stage 3: cos, cross product, fallback squares ----------------
    logic                    v3_reg;
    logic signed [C_W-1:0]   c3_reg;
    logic signed [CR_W-1:0]  cr3_reg [3];
    logic signed [V_W-1:0]   vv3_reg [3];
    logic [MAG_W-1:0]        vsq3_reg [3];
    logic signed [DOT_W-1:0] dsum;
    logic signed [2*V_W-1:0] vsq [3];

    always_comb
    begin
        dsum = DOT_W'(pd2_reg[0]) + DOT_W'(pd2_reg[1]) + DOT_W'(pd2_reg[2]);
        for (int i = 0; i < 3; i++)
            vsq[i] = vv2_reg[i] * vv2_reg[i];
    end

    always_ff @(posedge clk)
    begin
        c3_reg <= C_W'((dsum + RND_HALF) >>> FRAC_BITS);
        for (int i = 0; i < 3; i++)
        begin
            cr3_reg[i]  <= CR_W'(pc2_reg[2*i]) - CR_W'(pc2_reg[2*i+1]);
            vv3_reg[i]  <= vv2_reg[i];
            vsq3_reg[i] <= vsq[i][MAG_W-1:0];
        end
    end

    // ---------------- stage 4: squares of the cross product ----------------
    logic                   v4_reg;
    logic [SQ_W-1:0]        sq4_reg [3];
    logic [MAG_W-1:0]       vsum4_reg;
    root_side_t             side4_reg;
    logic signed [CR_W-1:0] crneg [3];
    logic [MAG_W-1:0]       crmag [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            crneg[i] = -cr3_reg[i];
            crmag[i] = cr3_reg[i][CR_W-1] ? crneg[i][MAG_W-1:0] : cr3_reg[i][MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            sq4_reg[i] <= crmag[i] * crmag[i];
        vsum4_reg     <= vsq3_reg[0] + vsq3_reg[1] + vsq3_reg[2];
        side4_reg.c   <= c3_reg;
        side4_reg.crx <= cr3_reg[0];
        side4_reg.cry <= cr3_reg[1];
        side4_reg.crz <= cr3_reg[2];
        side4_reg.vx  <= vv3_reg[0];
        side4_reg.vy  <= vv3_reg[1];
        side4_reg.vz  <= vv3_reg[2];
    end

    // ---------------- stage 5 and square root pipeline ----------------
    // lane l: |a x b|^2, lane m: |a x e_k|^2
    logic             rvld_reg [0:ROOT_W];
    logic [SQ_W-1:0]  lv_reg [0:ROOT_W];
    logic [SQ_W-1:0]  lr_reg [0:ROOT_W];
    logic [SQ_W-1:0]  mv_reg [0:ROOT_W];
    logic [SQ_W-1:0]  mr_reg [0:ROOT_W];
    root_side_t       rside_reg [0:ROOT_W];

    always_ff @(posedge clk)
    begin
        lv_reg[0]    <= sq4_reg[0] + sq4_reg[1] + sq4_reg[2];
        lr_reg[0]    <= '0;
        mv_reg[0]    <= SQ_W'(vsum4_reg);
        mr_reg[0]    <= '0;
        rside_reg[0] <= side4_reg;
    end

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        localparam int SH = 2 * (ROOT_W - 1 - g);
        sqrt_step_t lstep;
        sqrt_step_t mstep;

        assign lstep = sqrt_step(lv_reg[g], lr_reg[g], SQ_W'(1) << SH);
        assign mstep = sqrt_step(mv_reg[g], mr_reg[g], SQ_W'(1) << SH);

        always_ff @(posedge clk)
        begin
            lv_reg[g+1]    <= lstep.v;
            lr_reg[g+1]    <= lstep.r;
            mv_reg[g+1]    <= mstep.v;
            mr_reg[g+1]    <= mstep.r;
            rside_reg[g+1] <= rside_reg[g];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rvld_reg[g+1] <= 1'b0;
            else
                rvld_reg[g+1] <= rvld_reg[g];
        end
    end

    // ---------------- decide case, set up the axis division ----------------
    logic              dvld_reg [0:QB];
    logic [NUM_W-1:0]  drem_reg [0:QB][3];
    logic [QB-1:0]     dq_reg [0:QB][3];
    logic [DEN_W-1:0]  dden_reg [0:QB];
    div_side_t         dside_reg [0:QB];

    logic [ROOT_W-1:0]      len_root;
    logic [ROOT_W-1:0]      m_root;
    logic [ROOT_W:0]        len_rnd;
    logic [S_W-1:0]         s_val;
    logic                   collinear;
    logic                   opposite;
    logic [ROOT_W-1:0]      dsel;
    logic signed [CR_W-1:0] nsel [3];
    logic [NUM_W-1:0]       nfull [3];
    logic [NUM_W-1:0]       nmag [3];
    div_side_t              dside_next;

    always_comb
    begin
        len_root  = lr_reg[ROOT_W][ROOT_W-1:0];
        m_root    = mr_reg[ROOT_W][ROOT_W-1:0];
        len_rnd   = (ROOT_W+1)'(len_root) + (ROOT_W+1)'(RND_HALF);
        s_val     = S_W'(len_rnd >> FRAC_BITS);
        collinear = (s_val < S_W'(thresh_reg));
        opposite  = collinear && rside_reg[ROOT_W].c[C_W-1];
        if (opposite)
        begin
            dsel    = m_root;
            nsel[0] = CR_W'(rside_reg[ROOT_W].vx);
            nsel[1] = CR_W'(rside_reg[ROOT_W].vy);
            nsel[2] = CR_W'(rside_reg[ROOT_W].vz);
        end
        else
        begin
            dsel    = len_root;
            nsel[0] = rside_reg[ROOT_W].crx;
            nsel[1] = rside_reg[ROOT_W].cry;
            nsel[2] = rside_reg[ROOT_W].crz;
        end
        // round half up of n*2^F/d as floor((2n*2^F + d) / 2d)
        for (int i = 0; i < 3; i++)
        begin
            nfull[i] = (NUM_W'(nsel[i]) << (FRAC_BITS + 1)) + NUM_W'(dsel);
            nmag[i]  = nfull[i][NUM_W-1] ? -nfull[i] : nfull[i];
            dside_next.neg[i] = nfull[i][NUM_W-1];
        end
        dside_next.c    = rside_reg[ROOT_W].c;
        dside_next.s    = s_val;
        dside_next.zero = (dsel == '0);
        priority if (opposite)
            dside_next.kase = CASE_OPPOSITE;
        else if (collinear)
            dside_next.kase = CASE_SAME;
        else
            dside_next.kase = CASE_GENERAL;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            drem_reg[0][i] <= nmag[i];
            dq_reg[0][i]   <= '0;
        end
        dden_reg[0]  <= {dsel, 1'b0};
        dside_reg[0] <= dside_next;
    end

    // restoring division, one quotient bit per stage
    for (genvar g = 0; g < QB; g++)
    begin : g_div
        localparam int SH = QB - 1 - g;
        logic [NUM_W-1:0] dsh;
        logic             take [3];

        assign dsh = NUM_W'(dden_reg[g]) << SH;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
                take[i] = (drem_reg[g][i] >= dsh);
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[g+1][i] <= take[i] ? drem_reg[g][i] - dsh : drem_reg[g][i];
                dq_reg[g+1][i]   <= {dq_reg[g][i][QB-2:0], take[i]};
            end
            dden_reg[g+1]  <= dden_reg[g];
            dside_reg[g+1] <= dside_reg[g];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dvld_reg[g+1] <= 1'b0;
            else
                dvld_reg[g+1] <= dvld_reg[g];
        end
    end

    // ---------------- floor correction of the signed quotient ----------------
    logic                   vf_reg;
    logic signed [AX_W-1:0] axf_reg [3];
    logic signed [C_W-1:0]  cf_reg;
    logic [S_W-1:0]         sf_reg;
    case_t                  kf_reg;
    logic [AX_W-1:0]        qinc [3];
    logic signed [AX_W-1:0] ax_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qinc[i] = AX_W'(dq_reg[QB][i]) + AX_W'(drem_reg[QB][i] != '0);
            if (dside_reg[QB].zero)
                ax_next[i] = '0;
            else if (dside_reg[QB].neg[i])
                ax_next[i] = -$signed(qinc[i]);
            else
                ax_next[i] = $signed(AX_W'(dq_reg[QB][i]));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            axf_reg[i] <= ax_next[i];
        cf_reg <= dside_reg[QB].c;
        sf_reg <= dside_reg[QB].s;
        kf_reg <= dside_reg[QB].kase;
    end

    // ---------------- matrix stage 1: t*u and s*w ----------------
    logic                        vm1_reg;
    logic signed [TU_W-1:0]      tu1_reg [3];
    logic signed [SS_W-1:0]      ss1_reg [3];
    logic signed [AX_W-1:0]      ax1_reg [3];
    logic signed [C_W-1:0]       c1_reg;
    case_t                       k1_reg;
    logic signed [T_W-1:0]       t_val;
    logic signed [S_W:0]         s_sgn;
    logic signed [T_W+AX_W-1:0]  tp [3];
    logic signed [S_W+AX_W:0]    sp [3];

    always_comb
    begin
        t_val = T_W'(ONE) - T_W'(cf_reg);
        s_sgn = $signed({1'b0, sf_reg});
        for (int i = 0; i < 3; i++)
        begin
            tp[i] = t_val * axf_reg[i];
            sp[i] = s_sgn * axf_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            tu1_reg[i] <= TU_W'((tp[i] + RND_HALF) >>> FRAC_BITS);
            ss1_reg[i] <= SS_W'((sp[i] + RND_HALF) >>> FRAC_BITS);
            ax1_reg[i] <= axf_reg[i];
        end
        c1_reg <= cf_reg;
        k1_reg <= kf_reg;
    end

    // ---------------- matrix stage 2: t*u*v ----------------
    logic                          vm2_reg;
    logic signed [TUV_W-1:0]       tuv2_reg [3][3];
    logic signed [SS_W-1:0]        ss2_reg [3];
    logic signed [C_W-1:0]         c2_reg;
    case_t                         k2_reg;
    logic signed [TU_W+AX_W-1:0]   up [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                up[i][j] = tu1_reg[i] * ax1_reg[j];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                tuv2_reg[i][j] <= TUV_W'((up[i][j] + RND_HALF) >>> FRAC_BITS);
            ss2_reg[i] <= ss1_reg[i];
        end
        c2_reg <= c1_reg;
        k2_reg <= k1_reg;
    end

    // ---------------- output stage: sum, saturate, identity override ----------------
    logic                     done_reg;
    logic signed [OUT_W-1:0]  m_reg [3][3];
    case_t                    case_reg;
    logic signed [ENT_W-1:0]  ec;
    logic signed [ENT_W-1:0]  es [3];
    logic signed [ENT_W-1:0]  e [3][3];
    logic signed [OUT_W-1:0]  m_next [3][3];
    logic signed [OUT_W-1:0]  diag_one;

    always_comb
    begin
        ec = ENT_W'(c2_reg);
        for (int i = 0; i < 3; i++)
            es[i] = ENT_W'(ss2_reg[i]);
        e[0][0] = ENT_W'(tuv2_reg[0][0]) + ec;
        e[0][1] = ENT_W'(tuv2_reg[0][1]) + es[2];
        e[0][2] = ENT_W'(tuv2_reg[0][2]) - es[1];
        e[1][0] = ENT_W'(tuv2_reg[1][0]) - es[2];
        e[1][1] = ENT_W'(tuv2_reg[1][1]) + ec;
        e[1][2] = ENT_W'(tuv2_reg[1][2]) + es[0];
        e[2][0] = ENT_W'(tuv2_reg[2][0]) + es[1];
        e[2][1] = ENT_W'(tuv2_reg[2][1]) - es[0];
        e[2][2] = ENT_W'(tuv2_reg[2][2]) + ec;
        diag_one = sat_out(ENT_W'(ONE));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (k2_reg == CASE_SAME)
                    m_next[i][j] = (i == j) ? diag_one : '0;
                else
                    m_next[i][j] = sat_out(e[i][j]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m_reg[i][j] <= m_next[i][j];
        case_reg <= k2_reg;
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            rvld_reg[0] <= 1'b0;
            dvld_reg[0] <= 1'b0;
            vf_reg      <= 1'b0;
            vm1_reg     <= 1'b0;
            vm2_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            v1_reg      <= start && !busy;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            rvld_reg[0] <= v4_reg;
            dvld_reg[0] <= rvld_reg[ROOT_W];
            vf_reg      <= dvld_reg[QB];
            vm1_reg     <= vf_reg;
            vm2_reg     <= vm1_reg;
            done_reg    <= vm2_reg;
        end
    end

    assign done       = done_reg;
    assign m00        = m_reg[0][0];
    assign m01        = m_reg[0][1];
    assign m02        = m_reg[0][2];
    assign m10        = m_reg[1][0];
    assign m11        = m_reg[1][1];
    assign m12        = m_reg[1][2];
    assign m20        = m_reg[2][0];
    assign m21        = m_reg[2][1];
    assign m22        = m_reg[2][2];
    assign case_taken = case_reg;

    // ---------------- assertions ----------------
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a transaction accepted at the pipeline latency");

    a_same_is_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (done && case_taken == CASE_SAME) |->
            (m11 == m00 && m22 == m00 && m01 == '0 && m10 == '0 && m12 == '0 && m21 == '0))
        else $error("same-direction result is not the identity");

endmodule

// ----- sim/tb_rotation_between_unit_vectors.sv -----
// tb_rotation_between_unit_vectors: self-checking testbench for the rotation matrix block
// depends on rbuv_pkg and rotation_between_unit_vectors; holds its own bit-exact predictor
module tb_rotation_between_unit_vectors;
    import rbuv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RAND_PER_PHASE = 125;

    typedef logic signed [IN_W-1:0] fld_t;

    typedef struct {
        fld_t a[3];
        fld_t b[3];
    } pair_t;

    typedef struct {
        logic signed [OUT_W-1:0] m[9];
        case_t                   kase;
    } matrix_t;

    class rotation_scoreboard;
        matrix_t     expected_q[$];
        longint      thresh;
        int          mismatches;

        function new();
            thresh     = THR_RESET;
            mismatches = 0;
        endfunction

        static function longint fdiv(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q = q - 1;
            return q;
        endfunction

        static function longint rshift_rnd(longint v);
            return fdiv(v + (1 << (FRAC_BITS - 1)), longint'(1) << FRAC_BITS);
        endfunction

        static function longint div_rnd(longint n, longint d);
            return fdiv(2 * n + d, 2 * d);
        endfunction

        static function longint unsigned int_root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        static function logic signed [OUT_W-1:0] clip(longint v);
            if (v > SAT_HI)
                v = SAT_HI;
            if (v < SAT_LO)
                v = SAT_LO;
            return OUT_W'(v);
        endfunction

        static function longint tuv(longint t, longint u, longint v);
            return rshift_rnd(rshift_rnd(t * u) * v);
        endfunction

        function matrix_t rotation_of(pair_t p);
            matrix_t         r;
            longint          ax, ay, az, bx, by, bz;
            longint          one, c, s, t, x, y, z, cx, cy, cz;
            longint          a0, a1, a2, vx, vy, vz;
            longint unsigned len, m;
            int              k;
            ax = p.a[0]; ay = p.a[1]; az = p.a[2];
            bx = p.b[0]; by = p.b[1]; bz = p.b[2];
            one = longint'(1) << FRAC_BITS;
            x = 0; y = 0; z = 0;
            r.kase = CASE_GENERAL;
            c  = rshift_rnd(ax * bx + ay * by + az * bz);
            cx = ay * bz - az * by;
            cy = az * bx - ax * bz;
            cz = ax * by - ay * bx;
            len = int_root(longint'(cx * cx) + longint'(cy * cy) + longint'(cz * cz));
            s = rshift_rnd(longint'(len));
            if (s < thresh)
            begin
                if (c >= 0)
                begin
                    for (int i = 0; i < 9; i++)
                        r.m[i] = (i % 4 == 0) ? clip(one) : '0;
                    r.kase = CASE_SAME;
                    return r;
                end
                // opposite: pick the smallest component of a, lowest index on ties
                a0 = ax < 0 ? -ax : ax;
                a1 = ay < 0 ? -ay : ay;
                a2 = az < 0 ? -az : az;
                k = (a0 <= a1) ? ((a0 <= a2) ? 0 : 2) : ((a1 <= a2) ? 1 : 2);
                if (k == 0)
                begin
                    vx = 0; vy = az; vz = -ay;
                end
                else if (k == 1)
                begin
                    vx = -az; vy = 0; vz = ax;
                end
                else
                begin
                    vx = ay; vy = -ax; vz = 0;
                end
                m = int_root(vx * vx + vy * vy + vz * vz);
                if (m != 0)
                begin
                    x = div_rnd(vx * one, longint'(m));
                    y = div_rnd(vy * one, longint'(m));
                    z = div_rnd(vz * one, longint'(m));
                end
                r.kase = CASE_OPPOSITE;
            end
            else if (len != 0)
            begin
                x = div_rnd(cx * one, longint'(len));
                y = div_rnd(cy * one, longint'(len));
                z = div_rnd(cz * one, longint'(len));
            end
            t = one - c;
            r.m[0] = clip(tuv(t, x, x) + c);
            r.m[1] = clip(tuv(t, x, y) + rshift_rnd(s * z));
            r.m[2] = clip(tuv(t, x, z) - rshift_rnd(s * y));
            r.m[3] = clip(tuv(t, y, x) - rshift_rnd(s * z));
            r.m[4] = clip(tuv(t, y, y) + c);
            r.m[5] = clip(tuv(t, y, z) + rshift_rnd(s * x));
            r.m[6] = clip(tuv(t, z, x) + rshift_rnd(s * y));
            r.m[7] = clip(tuv(t, z, y) - rshift_rnd(s * x));
            r.m[8] = clip(tuv(t, z, z) + c);
            return r;
        endfunction

        function void note_pair(pair_t p);
            expected_q.push_back(rotation_of(p));
        endfunction

        function void report(string what, longint exp_v, longint act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
        endfunction

        function void check_matrix(matrix_t act);
            matrix_t e;
            if (expected_q.size() == 0)
            begin
                report("unexpected result, queue depth", 0, 1);
                return;
            end
            e = expected_q.pop_front();
            for (int i = 0; i < 9; i++)
                if (act.m[i] !== e.m[i])
                    report($sformatf("m%0d%0d", i / 3, i % 3), e.m[i], act.m[i]);
            if (act.kase !== e.kase)
                report("case_taken", e.kase, act.kase);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    fld_t from_x = '0, from_y = '0, from_z = '0, to_x = '0, to_y = '0, to_z = '0;
    logic done;
    logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic [1:0] case_taken;

    rotation_scoreboard sb = new();
    bit   gaps_on = 1'b1;
    int   quiet_cycles = 0;

    always #10 clk = ~clk;

    rotation_between_unit_vectors uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .from_x(from_x), .from_y(from_y), .from_z(from_z),
        .to_x(to_x), .to_y(to_y), .to_z(to_z),
        .done(done),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22), .case_taken(case_taken)
    );

    // result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        matrix_t act;
        if (rst_n && done)
        begin
            act.m[0] = m00; act.m[1] = m01; act.m[2] = m02;
            act.m[3] = m10; act.m[4] = m11; act.m[5] = m12;
            act.m[6] = m20; act.m[7] = m21; act.m[8] = m22;
            act.kase = case_t'(case_taken);
            sb.check_matrix(act);
        end
    end

    // watchdog: cycles in which no transaction moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic apb_write(input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = ADDR_W'(REG_THRESH) << 2;
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.thresh = val & 32'h3FFF;
        @(negedge clk);
        pwrite = 1'b0; penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== (val & 32'h3FFF))
            sb.report("threshold readback", val & 32'h3FFF, prdata);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    // called at a falling edge; returns at the next falling edge after acceptance
    task automatic send_pair(input pair_t p);
        while (gaps_on && $urandom_range(99) < 36)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        from_x = p.a[0]; from_y = p.a[1]; from_z = p.a[2];
        to_x = p.b[0]; to_y = p.b[1]; to_z = p.b[2];
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_pair(p);
        @(negedge clk);
    endtask

    // called at a falling edge right after the last send
    task automatic settle();
        start = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic fld_t clamp16(int v);
        if (v > SAT_HI)
            v = SAT_HI;
        if (v < SAT_LO)
            v = SAT_LO;
        return IN_W'(v);
    endfunction

    function automatic real urand01();
        return $urandom / 4294967296.0;
    endfunction

    function automatic void unit_vec(output fld_t v[3]);
        real zz, phi, rho;
        zz  = 2.0 * urand01() - 1.0;
        phi = 6.283185307 * urand01();
        rho = $sqrt(1.0 - zz * zz);
        v[0] = fld_t'($rtoi(rho * $cos(phi) * 16384.0));
        v[1] = fld_t'($rtoi(rho * $sin(phi) * 16384.0));
        v[2] = fld_t'($rtoi(zz * 16384.0));
    endfunction

    function automatic pair_t make_pair(fld_t a0, fld_t a1, fld_t a2,
                                        fld_t b0, fld_t b1, fld_t b2);
        pair_t p;
        p.a[0] = a0; p.a[1] = a1; p.a[2] = a2;
        p.b[0] = b0; p.b[1] = b1; p.b[2] = b2;
        return p;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int    sel, d, sgn;
        sel = $urandom_range(99);
        unit_vec(p.a);
        unit_vec(p.b);
        if (sel < 40)
            return p;
        if (sel < 80)
        begin
            // near-collinear: b is +/-a nudged by a few lsbs to straddle the threshold
            sgn = (sel < 60) ? 1 : -1;
            d = (sel % 4 == 0) ? 0 : $urandom_range(1, 1 << $urandom_range(0, 5));
            for (int i = 0; i < 3; i++)
                p.b[i] = clamp16(sgn * int'(p.a[i]) + $urandom_range(0, 2 * d) - d);
            return p;
        end
        if (sel < 88)
        begin
            // components with equal magnitudes exercise the tie rule for the chosen axis
            for (int i = 0; i < 3; i++)
            begin
                p.a[i] = fld_t'($urandom_range(1) ? 9459 : -9459);
                if ($urandom_range(2) == 0)
                    p.a[i] = '0;
                p.b[i] = clamp16(-int'(p.a[i]));
            end
            return p;
        end
        for (int i = 0; i < 3; i++)
        begin
            p.a[i] = fld_t'($urandom_range(65535));
            p.b[i] = fld_t'($urandom_range(65535));
        end
        return p;
    endfunction

    initial
    begin
        pair_t         directed[$];
        int unsigned   thresholds[6];
        thresholds = '{0, 16383, 1, 0, 2, 5};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed.push_back(make_pair(16384, 0, 0, 0, 16384, 0));
        directed.push_back(make_pair(0, 16384, 0, 0, 0, 16384));
        directed.push_back(make_pair(16384, 0, 0, 16384, 0, 0));
        directed.push_back(make_pair(16384, 0, 0, -16384, 0, 0));
        directed.push_back(make_pair(0, 16384, 0, 0, -16384, 0));
        directed.push_back(make_pair(0, 0, -16384, 0, 0, 16384));
        directed.push_back(make_pair(9459, 9459, 9459, -9459, -9459, -9459));
        directed.push_back(make_pair(0, 11585, 11585, 0, -11585, -11585));
        directed.push_back(make_pair(16384, 0, 0, 16384, 1, 0));
        directed.push_back(make_pair(16384, 0, 0, 16384, 2, 0));
        directed.push_back(make_pair(16384, 0, 0, -16384, 3, 0));
        directed.push_back(make_pair(0, 0, 0, 0, 0, 0));
        directed.push_back(make_pair(0, 0, 0, 16384, 0, 0));
        directed.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767));
        directed.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, 32767));
        directed.push_back(make_pair(-32768, 32767, -32768, 32767, -32768, 32767));
        directed.push_back(make_pair(32767, -32768, 0, -32768, 0, 32767));
        directed.push_back(make_pair(-1, -1, -1, 1, 1, 1));
        directed.push_back(make_pair(11585, -11585, 0, 0, 11585, 11585));
        foreach (directed[i])
            send_pair(directed[i]);
        for (int n = 0; n < RAND_PER_PHASE; n++)
            send_pair(random_pair());
        settle();

        apb_write(32'(THR_RESET));
        for (int ph = 0; ph < 6; ph++)
        begin
            apb_write(thresholds[ph]);
            // one phase back to back, with no gaps at all
            gaps_on = (ph != 3);
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_pair(random_pair());
            settle();
        end

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
